>>> sv/box_region_classifier_defines.svh
// assertion macros used by the classifier top level
// no dependencies; included by the top level, which carries concurrent checks
`ifndef BOX_REGION_CLASSIFIER_DEFINES_SVH
`define BOX_REGION_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define BRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is active
`define BRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/brc_pkg.sv
// shared types and constants of the box region classifier
// no dependencies; used by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps

package brc_pkg;

  localparam int OP_W       = 2;
  localparam int REGION_W   = 6;
  localparam int DIM_W      = 2;
  localparam int VERDICT_W  = 2;
  localparam int DIMS_CFG_W = 3;
  localparam int NUM_COORDS = 4;

  localparam logic [DIMS_CFG_W-1:0] DIMS_RESET   = 3'd4;
  localparam logic [VERDICT_W-1:0]  VERDICT_TRUE = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_BOUND   = 2'd0,
    OP_VERDICT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_run;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

  typedef struct packed {
    logic                 satisfied;
    logic                 matched;
    logic [REGION_W-1:0]  hit_region;
    logic [VERDICT_W-1:0] hit_verdict;
  } res_t;

endpackage

>>> sv/brc_in_if.sv
// input channel of the classifier: valid/ready plus one item payload
// depends on brc_pkg for field widths
`timescale 1ns / 1ps

interface brc_in_if import brc_pkg::*; #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               operation;
  logic [REGION_W-1:0]           region_index;
  logic [DIM_W-1:0]              dim_index;
  logic signed [COORD_WIDTH-1:0] bound_low;
  logic signed [COORD_WIDTH-1:0] bound_high;
  logic [VERDICT_W-1:0]          verdict_in;
  logic signed [COORD_WIDTH-1:0] coord_0;
  logic signed [COORD_WIDTH-1:0] coord_1;
  logic signed [COORD_WIDTH-1:0] coord_2;
  logic signed [COORD_WIDTH-1:0] coord_3;

  modport source (
    output valid, operation, region_index, dim_index, bound_low, bound_high,
           verdict_in, coord_0, coord_1, coord_2, coord_3,
    input  ready
  );

  modport sink (
    input  valid, operation, region_index, dim_index, bound_low, bound_high,
           verdict_in, coord_0, coord_1, coord_2, coord_3,
    output ready
  );
endinterface

>>> sv/brc_out_if.sv
// result channel of the classifier: valid/ready plus one result payload
// depends on brc_pkg for field widths
`timescale 1ns / 1ps

interface brc_out_if import brc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 satisfied;
  logic                 matched;
  logic [REGION_W-1:0]  hit_region;
  logic [VERDICT_W-1:0] hit_verdict;

  modport source (
    output valid, satisfied, matched, hit_region, hit_verdict,
    input  ready
  );

  modport sink (
    input  valid, satisfied, matched, hit_region, hit_verdict,
    output ready
  );
endinterface

>>> sv/brc_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module brc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/brc_ctrl.sv
// controller of the classifier: accepts items, runs the region scan, loads the output
// depends on brc_pkg for command and status structs
`timescale 1ns / 1ps

module brc_ctrl import brc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_query_i,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output ctrl_cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // output register is free or is being emptied this cycle
  assign load_out   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.accept     = accept;
    cmd_o.scan_start = accept && in_query_i;
    cmd_o.scan_run   = (state_q == ST_SCAN);
    cmd_o.load_out   = load_out;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = in_query_i ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

>>> sv/brc_datapath.sv
// datapath of the classifier: region tables, dims register, scan pipeline, result registers
// depends on brc_pkg and brc_ram
`timescale 1ns / 1ps

module brc_datapath import brc_pkg::*; #(
  parameter int MAX_REGIONS = 64,
  parameter int MAX_DIMS    = 4,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [DIMS_CFG_W-1:0]         cfg_wdata_i,
  input  ctrl_cmd_t                     cmd_i,
  output dp_status_t                    status_o,
  input  logic [OP_W-1:0]               operation_i,
  input  logic [REGION_W-1:0]           region_index_i,
  input  logic [DIM_W-1:0]              dim_index_i,
  input  logic signed [COORD_WIDTH-1:0] bound_low_i,
  input  logic signed [COORD_WIDTH-1:0] bound_high_i,
  input  logic [VERDICT_W-1:0]          verdict_in_i,
  input  logic signed [COORD_WIDTH-1:0] coord_0_i,
  input  logic signed [COORD_WIDTH-1:0] coord_1_i,
  input  logic signed [COORD_WIDTH-1:0] coord_2_i,
  input  logic signed [COORD_WIDTH-1:0] coord_3_i,
  output res_t                          res_o
);
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  // dimensions beyond the point's coordinates are never compared
  localparam int LANES = (MAX_DIMS < NUM_COORDS) ? MAX_DIMS : NUM_COORDS;

  op_e                          op;
  logic                         reg_ok;
  logic [IDX_W-1:0]             wr_addr;
  logic [IDX_W-1:0]             rd_addr;
  logic                         verdict_we;
  logic signed [COORD_WIDTH-1:0] coord_in [NUM_COORDS];
  logic [2*COORD_WIDTH-1:0]     bound_rd [LANES];
  logic [VERDICT_W-1:0]         verdict_rd;
  logic [LANES-1:0]             in_lane;
  logic                         box_hit;

  logic [DIMS_CFG_W-1:0]         dims_q;
  logic                          valid_q [MAX_REGIONS];
  logic signed [COORD_WIDTH-1:0] point_q [LANES];
  logic [CNT_W-1:0]              issue_cnt_q;
  logic                          chk_vld_q;
  logic [IDX_W-1:0]              chk_idx_q;
  res_t                          res_q;
  res_t                          out_q;

  assign op       = op_e'(operation_i);
  assign reg_ok   = 32'(region_index_i) < MAX_REGIONS;
  assign wr_addr  = IDX_W'(region_index_i);
  assign rd_addr  = issue_cnt_q[IDX_W-1:0];
  assign verdict_we = cmd_i.accept && (op == OP_VERDICT) && reg_ok;

  assign coord_in[0] = coord_0_i;
  assign coord_in[1] = coord_1_i;
  assign coord_in[2] = coord_2_i;
  assign coord_in[3] = coord_3_i;

  // one bound ram per dimension, {high, low} per region
  for (genvar d = 0; d < LANES; d++) begin : g_lane
    logic bound_we;
    assign bound_we = cmd_i.accept && (op == OP_BOUND) && reg_ok
                      && (32'(dim_index_i) == d);

    brc_ram #(
      .WIDTH (2 * COORD_WIDTH),
      .DEPTH (MAX_REGIONS)
    ) u_bound_ram (
      .clk_i   (clk_i),
      .we_i    (bound_we),
      .waddr_i (wr_addr),
      .wdata_i ({bound_high_i, bound_low_i}),
      .raddr_i (rd_addr),
      .rdata_o (bound_rd[d])
    );
  end

  brc_ram #(
    .WIDTH (VERDICT_W),
    .DEPTH (MAX_REGIONS)
  ) u_verdict_ram (
    .clk_i   (clk_i),
    .we_i    (verdict_we),
    .waddr_i (wr_addr),
    .wdata_i (verdict_in_i),
    .raddr_i (rd_addr),
    .rdata_o (verdict_rd)
  );

  // one signed range compare per dimension, disabled lanes pass
  always_comb begin
    for (int d = 0; d < LANES; d++) begin
      in_lane[d] = (32'(dims_q) <= d)
                   || ((point_q[d] >= $signed(bound_rd[d][COORD_WIDTH-1:0]))
                       && (point_q[d] <= $signed(bound_rd[d][2*COORD_WIDTH-1:COORD_WIDTH])));
    end
  end

  assign box_hit = valid_q[chk_idx_q] && (&in_lane);
  assign status_o.scan_done = chk_vld_q
                              && (box_hit || (32'(chk_idx_q) == MAX_REGIONS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q      <= DIMS_RESET;
      issue_cnt_q <= '0;
      chk_vld_q   <= 1'b0;
      for (int r = 0; r < MAX_REGIONS; r++) begin
        valid_q[r] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        dims_q <= cfg_wdata_i;
      end

      if (cmd_i.accept && (op == OP_CLEAR)) begin
        for (int r = 0; r < MAX_REGIONS; r++) begin
          valid_q[r] <= 1'b0;
        end
      end else if (verdict_we) begin
        valid_q[wr_addr] <= 1'b1;
      end

      if (cmd_i.scan_start) begin
        issue_cnt_q <= '0;
        chk_vld_q   <= 1'b0;
      end else if (cmd_i.scan_run) begin
        chk_vld_q <= 32'(issue_cnt_q) < MAX_REGIONS;
        if (32'(issue_cnt_q) < MAX_REGIONS) begin
          issue_cnt_q <= issue_cnt_q + CNT_W'(1);
        end
      end else begin
        chk_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_addr;
    if (cmd_i.accept) begin
      for (int d = 0; d < LANES; d++) begin
        point_q[d] <= coord_in[d];
      end
    end
    if (cmd_i.accept) begin
      res_q <= '0;
    end else if (cmd_i.scan_run && chk_vld_q && box_hit) begin
      res_q.satisfied   <= (verdict_rd == VERDICT_TRUE);
      res_q.matched     <= 1'b1;
      res_q.hit_region  <= REGION_W'(chk_idx_q);
      res_q.hit_verdict <= verdict_rd;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign res_o = out_q;
endmodule

>>> sv/box_region_classifier.sv
// top level of the box region classifier: controller, datapath and port wiring
// depends on brc_pkg, brc_in_if, brc_out_if, brc_ctrl, brc_datapath and the defines header
`timescale 1ns / 1ps
`include "box_region_classifier_defines.svh"

// usage
//   in_i carries one item per transaction: bound write, verdict write, table clear or
//   point query. out_o returns exactly one result transaction per item, in order; writes
//   and clears answer with all fields zero.
//   cfg_we_i/cfg_wdata_i load dims_in_use; write it only while the block is idle.
// flow and throughput
//   a write or clear goes from acceptance through the emit state to the output register.
//   a query scans regions in index order, one region per cycle, and stops at the first
//   containing box, or after the last region when none does.
//   the scan rate is set by one read per cycle of the per-dimension bound rams, all
//   dimensions compared side by side on the registered read data.
//   one item is in flight at a time; the next item is taken as soon as the previous
//   result sits in the output register.
// reset
//   all region valid bits clear at once, dims_in_use returns to 4; no clearing pass.
// stall
//   a result waits in the output register while out_o.ready is low; a following item is
//   still accepted and worked on, and waits for the output register before it completes.
module box_region_classifier import brc_pkg::*; #(
  parameter int MAX_REGIONS = 64,
  parameter int MAX_DIMS    = 4,
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [DIMS_CFG_W-1:0] cfg_wdata_i,
  brc_in_if.sink                in_i,
  brc_out_if.source             out_o
);
  ctrl_cmd_t  cmd;
  dp_status_t status;
  res_t       res;

  // controller owns the handshakes, datapath owns tables and payload
  brc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_query_i  (in_i.operation == OP_QUERY),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  brc_datapath #(
    .MAX_REGIONS (MAX_REGIONS),
    .MAX_DIMS    (MAX_DIMS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (in_i.operation),
    .region_index_i (in_i.region_index),
    .dim_index_i    (in_i.dim_index),
    .bound_low_i    (in_i.bound_low),
    .bound_high_i   (in_i.bound_high),
    .verdict_in_i   (in_i.verdict_in),
    .coord_0_i      (in_i.coord_0),
    .coord_1_i      (in_i.coord_1),
    .coord_2_i      (in_i.coord_2),
    .coord_3_i      (in_i.coord_3),
    .res_o          (res)
  );

  // result payload straight from the output register
  assign out_o.satisfied   = res.satisfied;
  assign out_o.matched     = res.matched;
  assign out_o.hit_region  = res.hit_region;
  assign out_o.hit_verdict = res.hit_verdict;

  // a query always occupies the block for at least the scan
  `BRC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni,
    in_i.valid && in_i.ready && (in_i.operation == OP_QUERY), !in_i.ready,
    "query accepted but block took another item next cycle")

  // a miss reports all-zero fields
  `BRC_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_o.valid && !out_o.matched,
    !out_o.satisfied && (out_o.hit_region == '0) && (out_o.hit_verdict == '0),
    "unmatched result carries nonzero fields")

  // satisfied only for a hit on a true verdict
  `BRC_ASSERT_NOW(a_sat_true, clk_i, rst_ni, out_o.valid && out_o.satisfied,
    out_o.matched && (out_o.hit_verdict == VERDICT_TRUE),
    "satisfied without a true verdict hit")
endmodule
